FILE: sv/lpi_pkg.sv
// Shared types and constants for the line pair intersection block.
// No dependencies.
package lpi_pkg;

  localparam int unsigned QBITS = 24;  // width of cross_x / cross_y

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PARALLEL = 2'd1;
  localparam logic [1:0] ST_SHALLOW  = 2'd2;

  localparam logic signed [QBITS-1:0] OUT_MAX = {1'b0, {(QBITS-1){1'b1}}};
  localparam logic signed [QBITS-1:0] OUT_MIN = {1'b1, {(QBITS-1){1'b0}}};

  // Control word that travels alongside each request through the divider chain.
  typedef struct packed {
    logic       vld;
    logic [1:0] status;
    logic       neg_x;
    logic       neg_y;
    logic       ovf_x;
    logic       ovf_y;
  } ctl_t;

endpackage

FILE: sv/lpi_front.sv
// Front pipeline: differences, cross/dot terms, numerators, magnitudes.
// Depends on lpi_pkg.
module lpi_front #(
  parameter int unsigned CW = 12,
  parameter int unsigned FB = 8,
  parameter int unsigned RW = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 in_valid_i,
  input  logic [CW-1:0]        a_start_x_i,
  input  logic [CW-1:0]        a_start_y_i,
  input  logic [CW-1:0]        a_end_x_i,
  input  logic [CW-1:0]        a_end_y_i,
  input  logic [CW-1:0]        b_start_x_i,
  input  logic [CW-1:0]        b_start_y_i,
  input  logic [CW-1:0]        b_end_x_i,
  input  logic [CW-1:0]        b_end_y_i,
  output lpi_pkg::ctl_t        ctl_o,
  output logic [RW-1:0]        rx_o,
  output logic [RW-1:0]        ry_o,
  output logic [2*CW+1:0]      dmag_o
);

  localparam int unsigned DW  = CW + 1;
  localparam int unsigned PW  = 2 * CW + 2;
  localparam int unsigned NXW = 3 * CW + 3;
  localparam int unsigned QB  = lpi_pkg::QBITS;

  // stage 1
  logic s1_vld_q;
  logic signed [DW-1:0] adx_d, ady_d, bdx_d, bdy_d;
  logic signed [DW-1:0] adx1_q, ady1_q, bdx1_q, bdy1_q;
  logic signed [2*DW-1:0] m_ab_q, m_ba_q, m_dy_q, m_dx_q;
  logic [2*CW-1:0] u1_q, u2_q, u3_q, u4_q;
  // stage 2
  logic s2_vld_q;
  logic signed [DW-1:0] adx2_q, ady2_q, bdx2_q, bdy2_q;
  logic signed [PW-1:0] d_q, dot_q, pa_q, pb_q;
  // stage 3
  logic s3_vld_q;
  logic [1:0] st_d, st3_q;
  logic [PW-1:0] dabs_d, dotabs_d, dmag3_q;
  logic dneg3_q;
  logic signed [NXW-1:0] pxa_q, pxb_q, pya_q, pyb_q;
  // stage 4
  logic s4_vld_q;
  logic [1:0] st4_q;
  logic [PW-1:0] dmag4_q;
  logic dneg4_q;
  logic signed [NXW-1:0] nx_q, ny_q;
  // stage 5
  logic [NXW-1:0] nxm_d, nym_d;
  logic [RW-1:0] rx_d, ry_d, dlim_d;
  lpi_pkg::ctl_t ctl_d, ctl_q;
  logic [RW-1:0] rx_q, ry_q;
  logic [PW-1:0] dmag5_q;

  assign adx_d = $signed({1'b0, a_start_x_i}) - $signed({1'b0, a_end_x_i});
  assign ady_d = $signed({1'b0, a_start_y_i}) - $signed({1'b0, a_end_y_i});
  assign bdx_d = $signed({1'b0, b_start_x_i}) - $signed({1'b0, b_end_x_i});
  assign bdy_d = $signed({1'b0, b_start_y_i}) - $signed({1'b0, b_end_y_i});

  assign dabs_d   = d_q[PW-1]   ? PW'(-d_q)   : PW'(d_q);
  assign dotabs_d = dot_q[PW-1] ? PW'(-dot_q) : PW'(dot_q);

  always_comb begin
    if (d_q == '0) begin
      st_d = lpi_pkg::ST_PARALLEL;
    end else if (dabs_d < dotabs_d) begin
      st_d = lpi_pkg::ST_SHALLOW;
    end else begin
      st_d = lpi_pkg::ST_OK;
    end
  end

  assign nxm_d  = nx_q[NXW-1] ? NXW'(-nx_q) : NXW'(nx_q);
  assign nym_d  = ny_q[NXW-1] ? NXW'(-ny_q) : NXW'(ny_q);
  assign rx_d   = RW'(nxm_d) << FB;
  assign ry_d   = RW'(nym_d) << FB;
  assign dlim_d = RW'(dmag4_q) << QB;

  always_comb begin
    ctl_d.vld    = s4_vld_q;
    ctl_d.status = st4_q;
    ctl_d.neg_x  = nx_q[NXW-1] ^ dneg4_q;
    ctl_d.neg_y  = ny_q[NXW-1] ^ dneg4_q;
    ctl_d.ovf_x  = rx_d >= dlim_d;
    ctl_d.ovf_y  = ry_d >= dlim_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      ctl_q    <= '0;
    end else if (en_i) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      ctl_q    <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adx1_q  <= adx_d;
      ady1_q  <= ady_d;
      bdx1_q  <= bdx_d;
      bdy1_q  <= bdy_d;
      m_ab_q  <= adx_d * bdy_d;
      m_ba_q  <= ady_d * bdx_d;
      m_dy_q  <= ady_d * bdy_d;
      m_dx_q  <= adx_d * bdx_d;
      u1_q    <= a_start_x_i * a_end_y_i;
      u2_q    <= a_start_y_i * a_end_x_i;
      u3_q    <= b_start_x_i * b_end_y_i;
      u4_q    <= b_start_y_i * b_end_x_i;

      adx2_q  <= adx1_q;
      ady2_q  <= ady1_q;
      bdx2_q  <= bdx1_q;
      bdy2_q  <= bdy1_q;
      d_q     <= PW'(m_ab_q) - PW'(m_ba_q);
      dot_q   <= PW'(m_dy_q) + PW'(m_dx_q);
      pa_q    <= $signed({2'b00, u1_q}) - $signed({2'b00, u2_q});
      pb_q    <= $signed({2'b00, u3_q}) - $signed({2'b00, u4_q});

      st3_q   <= st_d;
      dmag3_q <= dabs_d;
      dneg3_q <= d_q[PW-1];
      pxa_q   <= pa_q * bdx2_q;
      pxb_q   <= adx2_q * pb_q;
      pya_q   <= pa_q * bdy2_q;
      pyb_q   <= ady2_q * pb_q;

      st4_q   <= st3_q;
      dmag4_q <= dmag3_q;
      dneg4_q <= dneg3_q;
      nx_q    <= pxa_q - pxb_q;
      ny_q    <= pya_q - pyb_q;

      rx_q    <= rx_d;
      ry_q    <= ry_d;
      dmag5_q <= dmag4_q;
    end
  end

  assign ctl_o  = ctl_q;
  assign rx_o   = rx_q;
  assign ry_o   = ry_q;
  assign dmag_o = dmag5_q;

endmodule

FILE: sv/lpi_div_cell.sv
// One restoring-division cell: settles one quotient bit for x and for y.
// Depends on lpi_pkg.
module lpi_div_cell #(
  parameter int unsigned RW = 64,
  parameter int unsigned PW = 26,
  parameter int unsigned SH = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  lpi_pkg::ctl_t               ctl_i,
  input  logic [RW-1:0]               rx_i,
  input  logic [RW-1:0]               ry_i,
  input  logic [PW-1:0]               dmag_i,
  input  logic [lpi_pkg::QBITS-1:0]   qx_i,
  input  logic [lpi_pkg::QBITS-1:0]   qy_i,
  output lpi_pkg::ctl_t               ctl_o,
  output logic [RW-1:0]               rx_o,
  output logic [RW-1:0]               ry_o,
  output logic [PW-1:0]               dmag_o,
  output logic [lpi_pkg::QBITS-1:0]   qx_o,
  output logic [lpi_pkg::QBITS-1:0]   qy_o
);

  logic [RW-1:0] sub;
  logic take_x, take_y;
  logic [lpi_pkg::QBITS-1:0] qx_d, qy_d;
  lpi_pkg::ctl_t ctl_q;
  logic [RW-1:0] rx_q, ry_q;
  logic [PW-1:0] dmag_q;
  logic [lpi_pkg::QBITS-1:0] qx_q, qy_q;

  assign sub    = RW'(dmag_i) << SH;
  assign take_x = rx_i >= sub;
  assign take_y = ry_i >= sub;

  always_comb begin
    qx_d     = qx_i;
    qy_d     = qy_i;
    qx_d[SH] = take_x;
    qy_d[SH] = take_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q   <= take_x ? rx_i - sub : rx_i;
      ry_q   <= take_y ? ry_i - sub : ry_i;
      dmag_q <= dmag_i;
      qx_q   <= qx_d;
      qy_q   <= qy_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign rx_o   = rx_q;
  assign ry_o   = ry_q;
  assign dmag_o = dmag_q;
  assign qx_o   = qx_q;
  assign qy_o   = qy_q;

endmodule

FILE: sv/line_pair_intersection.sv
// Intersection of the lines through two segments. A request carries two
// segments in unsigned pixel coordinates; the result is status (0 accepted,
// 1 parallel, 2 angle under 45 degrees) and the crossing point in signed
// fixed point with FRAC_BITS fraction bits, truncated toward zero and
// saturated to 24 bits; rejected pairs return -1.0 in both coordinates.
// One request is taken every cycle while the output is not stalled; each result
// passes 5 front stages, a chain of 24 one-bit division cells and 1 output
// register. A stall on the output freezes the whole pipeline.
// Depends on lpi_pkg, lpi_front, lpi_div_cell.
module line_pair_intersection #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [COORD_BITS-1:0]               a_start_x_i,
  input  logic [COORD_BITS-1:0]               a_start_y_i,
  input  logic [COORD_BITS-1:0]               a_end_x_i,
  input  logic [COORD_BITS-1:0]               a_end_y_i,
  input  logic [COORD_BITS-1:0]               b_start_x_i,
  input  logic [COORD_BITS-1:0]               b_start_y_i,
  input  logic [COORD_BITS-1:0]               b_end_x_i,
  input  logic [COORD_BITS-1:0]               b_end_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic signed [lpi_pkg::QBITS-1:0]    cross_x_o,
  output logic signed [lpi_pkg::QBITS-1:0]    cross_y_o
);

  localparam int unsigned QB  = lpi_pkg::QBITS;
  localparam int unsigned PW  = 2 * COORD_BITS + 2;
  localparam int unsigned NXW = 3 * COORD_BITS + 3;
  localparam int unsigned NW  = NXW + FRAC_BITS;
  localparam int unsigned RW  = (NW > PW + QB) ? NW : PW + QB;

  function automatic logic signed [QB-1:0] sat_q(input logic [QB-1:0] mag,
                                                  input logic ovf, input logic neg);
    logic signed [QB-1:0] r;
    if (neg) begin
      if (ovf || (mag > (QB'(1) << (QB - 1)))) r = lpi_pkg::OUT_MIN;
      else r = -$signed(mag);
    end else begin
      if (ovf || mag[QB-1]) r = lpi_pkg::OUT_MAX;
      else r = $signed(mag);
    end
    return r;
  endfunction

  logic en;
  lpi_pkg::ctl_t ctl [0:QB];
  logic [RW-1:0] rx [0:QB];
  logic [RW-1:0] ry [0:QB];
  logic [PW-1:0] dmag [0:QB];
  logic [QB-1:0] qx [0:QB];
  logic [QB-1:0] qy [0:QB];

  logic out_vld_q;
  logic [1:0] status_q;
  logic signed [QB-1:0] cx_q, cy_q, cx_d, cy_d;
  logic signed [QB-1:0] reject_val;

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  lpi_front #(.CW(COORD_BITS), .FB(FRAC_BITS), .RW(RW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (in_valid_i),
    .a_start_x_i (a_start_x_i),
    .a_start_y_i (a_start_y_i),
    .a_end_x_i   (a_end_x_i),
    .a_end_y_i   (a_end_y_i),
    .b_start_x_i (b_start_x_i),
    .b_start_y_i (b_start_y_i),
    .b_end_x_i   (b_end_x_i),
    .b_end_y_i   (b_end_y_i),
    .ctl_o       (ctl[0]),
    .rx_o        (rx[0]),
    .ry_o        (ry[0]),
    .dmag_o      (dmag[0])
  );

  assign qx[0] = '0;
  assign qy[0] = '0;

  // cell g settles quotient bit QB-1-g
  for (genvar g = 0; g < QB; g++) begin : g_cell
    lpi_div_cell #(.RW(RW), .PW(PW), .SH(QB - 1 - g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl[g]),
      .rx_i   (rx[g]),
      .ry_i   (ry[g]),
      .dmag_i (dmag[g]),
      .qx_i   (qx[g]),
      .qy_i   (qy[g]),
      .ctl_o  (ctl[g+1]),
      .rx_o   (rx[g+1]),
      .ry_o   (ry[g+1]),
      .dmag_o (dmag[g+1]),
      .qx_o   (qx[g+1]),
      .qy_o   (qy[g+1])
    );
  end

  assign reject_val = QB'(0) - (QB'(1) << FRAC_BITS);

  always_comb begin
    if (ctl[QB].status == lpi_pkg::ST_OK) begin
      cx_d = sat_q(qx[QB], ctl[QB].ovf_x, ctl[QB].neg_x);
      cy_d = sat_q(qy[QB], ctl[QB].ovf_y, ctl[QB].neg_y);
    end else begin
      cx_d = reject_val;
      cy_d = reject_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= ctl[QB].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= ctl[QB].status;
      cx_q     <= cx_d;
      cy_q     <= cy_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = status_q;
  assign cross_x_o   = cx_q;
  assign cross_y_o   = cy_q;

endmodule

FILE: test/lpi_checker.sv
// Checker for line_pair_intersection: watches both channels, predicts each result
// from the accepted request and compares in order. Depends on lpi_pkg.
`timescale 1ns / 100ps
module lpi_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [11:0]              a_start_x_i,
  input  logic [11:0]              a_start_y_i,
  input  logic [11:0]              a_end_x_i,
  input  logic [11:0]              a_end_y_i,
  input  logic [11:0]              b_start_x_i,
  input  logic [11:0]              b_start_y_i,
  input  logic [11:0]              b_end_x_i,
  input  logic [11:0]              b_end_y_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [1:0]               status_i,
  input  logic signed [lpi_pkg::QBITS-1:0] cross_x_i,
  input  logic signed [lpi_pkg::QBITS-1:0] cross_y_i,
  output int                       fail_cnt_o,
  output int                       pending_o
);

  localparam int QB = lpi_pkg::QBITS;
  localparam int FRAC = 8;
  localparam longint QLIM = longint'(1) << 24;

  typedef struct {
    logic [1:0]           status;
    logic signed [QB-1:0] cx;
    logic signed [QB-1:0] cy;
  } crossing_t;

  crossing_t crossing_q[$];
  int fails_q = 0;

  // truncating Q8 quotient with clamping, num/den exact in 64 bits
  function automatic logic signed [QB-1:0] q8_quotient(longint num, longint den);
    longint q, r, res;
    q = num / den;
    r = num % den;
    if (q > QLIM) q = QLIM;
    if (q < -QLIM) q = -QLIM;
    res = q * (longint'(1) << FRAC) + (r * (longint'(1) << FRAC)) / den;
    if (res > longint'(lpi_pkg::OUT_MAX)) res = longint'(lpi_pkg::OUT_MAX);
    if (res < longint'(lpi_pkg::OUT_MIN)) res = longint'(lpi_pkg::OUT_MIN);
    return res[QB-1:0];
  endfunction

  function automatic crossing_t line_crossing(longint ax1, longint ay1, longint ax2,
                                              longint ay2, longint bx1, longint by1,
                                              longint bx2, longint by2);
    crossing_t c;
    longint adx, ady, bdx, bdy, d, dot, pa, pb, ad, adot;
    adx = ax1 - ax2;
    ady = ay1 - ay2;
    bdx = bx1 - bx2;
    bdy = by1 - by2;
    d   = adx * bdy - ady * bdx;
    dot = ady * bdy + adx * bdx;
    ad   = d < 0 ? -d : d;
    adot = dot < 0 ? -dot : dot;
    c.cx = QB'(-(longint'(1) << FRAC));
    c.cy = QB'(-(longint'(1) << FRAC));
    if (d == 0) begin
      c.status = lpi_pkg::ST_PARALLEL;
    end else if (ad < adot) begin
      c.status = lpi_pkg::ST_SHALLOW;
    end else begin
      pa = ax1 * ay2 - ay1 * ax2;
      pb = bx1 * by2 - by1 * bx2;
      c.status = lpi_pkg::ST_OK;
      c.cx = q8_quotient(pa * bdx - adx * pb, d);
      c.cy = q8_quotient(pa * bdy - ady * pb, d);
    end
    return c;
  endfunction

  assign pending_o  = crossing_q.size();
  assign fail_cnt_o = fails_q;

  always @(posedge clk_i) begin
    crossing_t want;
    int errs;
    errs = 0;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i)
        crossing_q.insert(crossing_q.size(),
                          line_crossing(longint'(a_start_x_i), longint'(a_start_y_i),
                                        longint'(a_end_x_i), longint'(a_end_y_i),
                                        longint'(b_start_x_i), longint'(b_start_y_i),
                                        longint'(b_end_x_i), longint'(b_end_y_i)));
      if (out_valid_i && out_ready_i) begin
        if (crossing_q.size() == 0) begin
          $error("result with no request outstanding");
          errs = errs + 1;
        end else begin
          want = crossing_q.pop_front();
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            errs = errs + 1;
          end
          if (cross_x_i !== want.cx) begin
            $error("cross_x: expected %0d, got %0d", want.cx, cross_x_i);
            errs = errs + 1;
          end
          if (cross_y_i !== want.cy) begin
            $error("cross_y: expected %0d, got %0d", want.cy, cross_y_i);
            errs = errs + 1;
          end
        end
      end
    end
    fails_q <= fails_q + errs;
  end
endmodule

FILE: test/tb_top.sv
// Top of the line_pair_intersection testbench: clock, reset, request stimulus,
// output back-pressure and verdict. Depends on lpi_pkg, lpi_checker and the block.
`timescale 1ns / 100ps
module tb_top;

  localparam int NUM_RAND   = 1130;
  localparam int STALL_LIM  = 3000;
  localparam int HOLD_LEN   = 250;
  localparam int DRAIN_WAIT = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [11:0] ax1 = '0, ay1 = '0, ax2 = '0, ay2 = '0;
  logic [11:0] bx1 = '0, by1 = '0, bx2 = '0, by2 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic signed [lpi_pkg::QBITS-1:0] cross_x, cross_y;
  int fails, pending;
  int sent = 0;
  int idle_cycles = 0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  always #5 clk = ~clk;

  line_pair_intersection uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .a_start_x_i(ax1), .a_start_y_i(ay1), .a_end_x_i(ax2), .a_end_y_i(ay2),
    .b_start_x_i(bx1), .b_start_y_i(by1), .b_end_x_i(bx2), .b_end_y_i(by2),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .status_o(status), .cross_x_o(cross_x), .cross_y_o(cross_y)
  );

  lpi_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .a_start_x_i(ax1), .a_start_y_i(ay1), .a_end_x_i(ax2), .a_end_y_i(ay2),
    .b_start_x_i(bx1), .b_start_y_i(by1), .b_end_x_i(bx2), .b_end_y_i(by2),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .status_i(status), .cross_x_i(cross_x), .cross_y_i(cross_y),
    .fail_cnt_o(fails), .pending_o(pending)
  );

  // output side: random stalls, a calm window, and one long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_done && sent >= 300) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (sent >= 450 && sent < 650) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 10);
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIM) begin
      $display("FAILURE");
      $finish;
    end
  end

  // valid stays high from one request to the next unless an idle cycle is drawn
  task automatic send_pair(input int p0, p1, p2, p3, p4, p5, p6, p7);
    if (!(sent >= 450 && sent < 650)) begin
      while ($urandom_range(99) < 10) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    ax1 <= 12'(p0); ay1 <= 12'(p1); ax2 <= 12'(p2); ay2 <= 12'(p3);
    bx1 <= 12'(p4); by1 <= 12'(p5); bx2 <= 12'(p6); by2 <= 12'(p7);
    in_valid <= 1'b1;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    sent++;
  endtask

  function automatic logic [11:0] near(logic [11:0] c);
    int v;
    v = int'(c) + int'($urandom_range(16)) - 8;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  initial begin
    logic [11:0] p[8];
    logic [11:0] dx, dy;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: degenerate, extremes, perpendicular, exactly 45 degrees, shallow
    send_pair(0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
    send_pair(0, 0, 4095, 0, 0, 4095, 4095, 4095);
    send_pair(0, 0, 4095, 0, 0, 0, 0, 4095);
    send_pair(0, 2048, 4095, 2048, 1000, 0, 1000, 4095);
    send_pair(0, 0, 1, 0, 0, 0, 1, 1);
    send_pair(0, 0, 1, 0, 0, 0, 2, 1);
    send_pair(0, 0, 4095, 4095, 4095, 0, 0, 4095);
    send_pair(0, 4095, 4095, 0, 0, 0, 4095, 4095);
    send_pair(0, 0, 4095, 4095, 0, 1, 4094, 4095);
    send_pair(4095, 0, 0, 1, 4095, 4095, 4094, 0);
    send_pair(0, 0, 1, 0, 4095, 4095, 4095, 4094);
    send_pair(4095, 4095, 0, 0, 4095, 4094, 1, 0);
    send_pair(1, 0, 0, 4095, 4095, 1, 0, 0);
    send_pair(0, 0, 0, 0, 0, 0, 4095, 4095);
    send_pair(4095, 4095, 4095, 0, 0, 4095, 4095, 4095);

    for (int i = 0; i < NUM_RAND; i++) begin
      if (i == 800) begin
        // let the pipeline drain completely before continuing
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      foreach (p[k]) p[k] = 12'($urandom_range(4095));
      case ($urandom_range(9))
        0: begin  // parallel: B is A shifted
          dx = 12'($urandom_range(64)); dy = 12'($urandom_range(64));
          p[2] = p[0] + dx; p[3] = p[1] + dy;
          p[4] = p[0] - 12'd100; p[5] = p[1] + 12'd7;
          p[6] = p[4] + dx; p[7] = p[5] + dy;
        end
        1: begin  // short segments close together
          p[2] = near(p[0]); p[3] = near(p[1]);
          p[4] = near(p[0]); p[5] = near(p[1]);
          p[6] = near(p[4]); p[7] = near(p[5]);
        end
        2: begin  // edge coordinates
          foreach (p[k]) p[k] = $urandom_range(1) ? 12'd4095 : 12'd0;
        end
        3: begin  // roughly perpendicular long lines
          p[2] = p[0] + 12'd800; p[3] = p[1] + 12'd5;
          p[4] = near(p[0]); p[6] = near(p[0]) + 12'd3;
          p[5] = 12'd0; p[7] = 12'd4095;
        end
        default: ;
      endcase
      send_pair(int'(p[0]), int'(p[1]), int'(p[2]), int'(p[3]),
                int'(p[4]), int'(p[5]), int'(p[6]), int'(p[7]));
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

FILE: filelist.f
sv/lpi_pkg.sv
sv/lpi_front.sv
sv/lpi_div_cell.sv
sv/line_pair_intersection.sv
test/lpi_checker.sv
test/tb_top.sv
